[hdl/dmanq_pkg.sv]
// Shared types, widths, register indexes and reset values for the dual
// moving average note quantizer. No dependencies.
package dmanq_pkg;

  localparam int WINDOW_DEF    = 50;
  localparam int NUM_NOTES_DEF = 4;

  localparam int SAMPLE_W   = 10;
  localparam int SUM_W      = 16;
  localparam int NOTE_W     = 7;
  localparam int NOTE_REGS  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_START = 3'd0,
    REG_RANGE_END   = 3'd1,
    REG_TRANSPOSE   = 3'd2,
    REG_NOTE_ZERO   = 3'd3,
    REG_NOTE_ONE    = 3'd4,
    REG_NOTE_TWO    = 3'd5,
    REG_NOTE_THREE  = 3'd6
  } cfg_reg_t;

  localparam logic [SAMPLE_W-1:0] RANGE_START_RST = 10'd120;
  localparam logic [SAMPLE_W-1:0] RANGE_END_RST   = 10'd590;
  localparam logic [NOTE_W-1:0]   TRANSPOSE_RST   = 7'd0;
  localparam logic [NOTE_W-1:0]   NOTE_ZERO_RST   = 7'd71;
  localparam logic [NOTE_W-1:0]   NOTE_ONE_RST    = 7'd68;
  localparam logic [NOTE_W-1:0]   NOTE_TWO_RST    = 7'd62;
  localparam logic [NOTE_W-1:0]   NOTE_THREE_RST  = 7'd59;

  typedef struct packed {
    logic [SAMPLE_W-1:0]                range_start;
    logic [SAMPLE_W-1:0]                range_end;
    logic signed [NOTE_W-1:0]           transpose;
    logic [NOTE_REGS-1:0][NOTE_W-1:0]   notes;
  } cfg_t;

endpackage

[hdl/dual_moving_average_note_quantizer_unit.sv]
// Dual moving average note quantizer, top level.
// Throughput 1 item per cycle unless out_ready stalls the output, set by the single
// read and single write port of each channel's sample ring.
// Reset: synchronous; clears pipeline valids, ring valid bits, totals and slot,
// and loads the register defaults at once. No clearing pass is needed.
// Depends on dmanq_pkg, dmanq_chan, dmanq_avg and dmanq_quant.
module dual_moving_average_note_quantizer_unit #(
  parameter int WINDOW    = dmanq_pkg::WINDOW_DEF,
  parameter int NUM_NOTES = dmanq_pkg::NUM_NOTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dmanq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmanq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dmanq_pkg::SAMPLE_W-1:0]   sample_a,
  input  logic [dmanq_pkg::SAMPLE_W-1:0]   sample_b,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dmanq_pkg::NOTE_W-1:0]     note,
  output logic [dmanq_pkg::SAMPLE_W-1:0]   level
);

  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_MAX = ((1 << dmanq_pkg::SAMPLE_W) - 1) * WINDOW;

  // Pipeline:
  //   accept -> s1 : samples and slot captured, ring entries read
  //   s1 -> s2     : ring written, running totals updated (totals are s2)
  //   s2 -> s3     : totals divided by WINDOW
  //   s3 -> out    : channel A quantized, channel B passed as level
  // Every stage moves when the one after it is empty or moving.

  dmanq_pkg::cfg_t cfg;

  logic                           accept;
  logic                           out_open;
  logic                           s3_open;
  logic                           s2_open;
  logic                           s1_open;
  logic                           s1_adv;
  logic                           s2_adv;
  logic                           s3_adv;
  logic                           s1_valid;
  logic                           s2_valid;
  logic                           s3_valid;
  logic [SLOT_W-1:0]              slot;
  logic [SLOT_W-1:0]              slot_next;
  logic [SLOT_W-1:0]              s1_slot;
  logic [dmanq_pkg::SAMPLE_W-1:0] s1_a;
  logic [dmanq_pkg::SAMPLE_W-1:0] s1_b;
  logic [dmanq_pkg::SUM_W-1:0]    sum_a;
  logic [dmanq_pkg::SUM_W-1:0]    sum_b;
  logic [dmanq_pkg::SAMPLE_W-1:0] avg_a;
  logic [dmanq_pkg::SAMPLE_W-1:0] avg_b;

  // Configuration registers; an index past the list writes nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_start <= dmanq_pkg::RANGE_START_RST;
      cfg.range_end   <= dmanq_pkg::RANGE_END_RST;
      cfg.transpose   <= dmanq_pkg::TRANSPOSE_RST;
      cfg.notes[0]    <= dmanq_pkg::NOTE_ZERO_RST;
      cfg.notes[1]    <= dmanq_pkg::NOTE_ONE_RST;
      cfg.notes[2]    <= dmanq_pkg::NOTE_TWO_RST;
      cfg.notes[3]    <= dmanq_pkg::NOTE_THREE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dmanq_pkg::REG_RANGE_START: cfg.range_start <= cfg_data;
        dmanq_pkg::REG_RANGE_END:   cfg.range_end   <= cfg_data;
        dmanq_pkg::REG_TRANSPOSE:   cfg.transpose   <= cfg_data[dmanq_pkg::NOTE_W-1:0];
        dmanq_pkg::REG_NOTE_ZERO:   cfg.notes[0]    <= cfg_data[dmanq_pkg::NOTE_W-1:0];
        dmanq_pkg::REG_NOTE_ONE:    cfg.notes[1]    <= cfg_data[dmanq_pkg::NOTE_W-1:0];
        dmanq_pkg::REG_NOTE_TWO:    cfg.notes[2]    <= cfg_data[dmanq_pkg::NOTE_W-1:0];
        dmanq_pkg::REG_NOTE_THREE:  cfg.notes[3]    <= cfg_data[dmanq_pkg::NOTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake and stage movement.
  assign out_open = !out_valid || out_ready;
  assign s3_open  = !s3_valid || out_open;
  assign s2_open  = !s2_valid || s3_open;
  assign s1_open  = !s1_valid || s2_open;
  assign in_ready = s1_open;
  assign accept   = in_valid && in_ready;
  assign s1_adv   = s1_valid && s2_open;
  assign s2_adv   = s2_valid && s3_open;
  assign s3_adv   = s3_valid && out_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= accept || (s1_valid && !s2_open);
      s2_valid  <= s1_adv || (s2_valid && !s3_open);
      s3_valid  <= s2_adv || (s3_valid && !out_open);
      out_valid <= s3_adv || (out_valid && !out_ready);
    end
  end

  // Ring write position: advance per accepted item, wrap at WINDOW.
  assign slot_next = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (accept) begin
      slot <= slot_next;
    end
  end

  // Hold the input item in s1 while its ring entries are read.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_a    <= sample_a;
      s1_b    <= sample_b;
      s1_slot <= slot;
    end
  end

  dmanq_chan #(.WINDOW(WINDOW)) u_chan_a (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (slot),
    .wr_en   (s1_adv),
    .wr_addr (s1_slot),
    .wr_data (s1_a),
    .sum     (sum_a)
  );

  dmanq_chan #(.WINDOW(WINDOW)) u_chan_b (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (slot),
    .wr_en   (s1_adv),
    .wr_addr (s1_slot),
    .wr_data (s1_b),
    .sum     (sum_b)
  );

  dmanq_avg #(.WINDOW(WINDOW)) u_avg_a (
    .clk (clk),
    .en  (s2_adv),
    .sum (sum_a),
    .avg (avg_a)
  );

  dmanq_avg #(.WINDOW(WINDOW)) u_avg_b (
    .clk (clk),
    .en  (s2_adv),
    .sum (sum_b),
    .avg (avg_b)
  );

  dmanq_quant #(.NUM_NOTES(NUM_NOTES)) u_quant (
    .clk   (clk),
    .cfg   (cfg),
    .en    (s3_adv),
    .value (avg_a),
    .note  (note)
  );

  // Channel B's average goes out as the level, beside the note.
  always_ff @(posedge clk) begin
    if (s3_adv) begin
      level <= avg_b;
    end
  end

  // Checks.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= SLOT_W'(WINDOW - 1))
    else $error("ring slot beyond window");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (sum_a <= dmanq_pkg::SUM_W'(SUM_MAX)) && (sum_b <= dmanq_pkg::SUM_W'(SUM_MAX)))
    else $error("running total exceeds full-scale window sum");

  a_s1_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> (s1_valid && (s1_slot == $past(slot))))
    else $error("accepted item not held in s1 with its slot");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && s3_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while every stage is stalled");

endmodule

[hdl/dmanq_chan.sv]
// One channel's sample ring (memory with per-entry valid bits) and its
// running total. Depends on dmanq_pkg.
module dmanq_chan #(
  parameter int WINDOW = dmanq_pkg::WINDOW_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        rd_en,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] rd_addr,
  input  logic                                        wr_en,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] wr_addr,
  input  logic [dmanq_pkg::SAMPLE_W-1:0]              wr_data,
  output logic [dmanq_pkg::SUM_W-1:0]                 sum
);

  logic [dmanq_pkg::SAMPLE_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0]              live;
  logic [dmanq_pkg::SAMPLE_W-1:0] mem_rd;
  logic [dmanq_pkg::SAMPLE_W-1:0] byp_data;
  logic                           rd_live;
  logic                           rd_byp;
  logic [dmanq_pkg::SAMPLE_W-1:0] old;
  logic [dmanq_pkg::SUM_W-1:0]    sum_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rd   <= mem[rd_addr];
      byp_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      rd_live <= 1'b0;
      rd_byp  <= 1'b0;
      sum     <= '0;
    end else begin
      if (wr_en) begin
        live[wr_addr] <= 1'b1;
        sum           <= sum_next;
      end
      if (rd_en) begin
        rd_live <= live[rd_addr];
        rd_byp  <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // never-written entries read as zero; forward a same-slot write
  assign old = rd_byp ? byp_data : (rd_live ? mem_rd : '0);

  assign sum_next = sum - dmanq_pkg::SUM_W'(old) + dmanq_pkg::SUM_W'(wr_data);

endmodule

[hdl/dmanq_avg.sv]
// Registered truncating divide of a running total by WINDOW, done as a
// multiply by a rounded-up reciprocal. Depends on dmanq_pkg.
module dmanq_avg #(
  parameter int WINDOW = dmanq_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [dmanq_pkg::SUM_W-1:0]    sum,
  output logic [dmanq_pkg::SAMPLE_W-1:0] avg
);

  localparam int DIV_SHIFT = dmanq_pkg::SUM_W + $clog2(WINDOW);
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int MULT_W    = dmanq_pkg::SUM_W + 2;
  localparam int PROD_W    = dmanq_pkg::SUM_W + MULT_W;

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(sum) * PROD_W'(MULT_W'(DIV_MULT));

  always_ff @(posedge clk) begin
    if (en) begin
      avg <= prod[DIV_SHIFT +: dmanq_pkg::SAMPLE_W];
    end
  end

endmodule

[hdl/dmanq_quant.sv]
// Note quantizer: segment bounds derived from configuration in two register
// steps, then segment match, nearer-end rule, transpose and saturation.
// Depends on dmanq_pkg.
module dmanq_quant #(
  parameter int NUM_NOTES = dmanq_pkg::NUM_NOTES_DEF
) (
  input  logic                           clk,
  input  dmanq_pkg::cfg_t                cfg,
  input  logic                           en,
  input  logic [dmanq_pkg::SAMPLE_W-1:0] value,
  output logic [dmanq_pkg::NOTE_W-1:0]   note
);

  localparam int SW       = dmanq_pkg::SAMPLE_W;
  localparam int NW       = dmanq_pkg::NOTE_W;
  localparam int Q_SHIFT  = SW + $clog2(NUM_NOTES);
  localparam int Q_MULT   = ((1 << Q_SHIFT) + NUM_NOTES - 1) / NUM_NOTES;
  localparam int Q_MULT_W = SW + 3;
  localparam int Q_PROD_W = SW + Q_MULT_W;
  localparam int BOUND_W  = SW + 1;
  localparam int LAST     = (NUM_NOTES > dmanq_pkg::NOTE_REGS) ?
                            dmanq_pkg::NOTE_REGS - 1 : NUM_NOTES - 1;

  logic signed [SW:0]    diff;
  logic [Q_PROD_W-1:0]   prod;
  logic [SW-1:0]         seg;
  logic [SW-1:0]         seg_next;
  logic [BOUND_W-1:0]    bound      [NUM_NOTES+1];
  logic [BOUND_W-1:0]    bound_next [NUM_NOTES+1];
  logic [NUM_NOTES-1:0]  hit;
  logic [NW-1:0]         hit_note;
  logic [NW-1:0]         base;
  logic signed [SW+1:0]  d_lo;
  logic signed [SW+1:0]  d_hi;
  logic [SW:0]           a_lo;
  logic [SW:0]           a_hi;
  logic                  near_lo;
  logic signed [NW+1:0]  sum9;
  logic [NW-1:0]         note_next;

  // segment length, floor of span / NUM_NOTES, zero for an empty or reversed span
  assign diff = $signed({1'b0, cfg.range_end}) - $signed({1'b0, cfg.range_start});
  assign prod = Q_PROD_W'(diff[SW-1:0]) * Q_PROD_W'(Q_MULT_W'(Q_MULT));
  assign seg_next = diff[SW] ? '0 : prod[Q_SHIFT +: SW];

  always_comb begin
    for (int i = 0; i <= NUM_NOTES; i++) begin
      bound_next[i] = BOUND_W'(cfg.range_start) + BOUND_W'(seg * SW'(i));
    end
  end

  always_ff @(posedge clk) begin
    seg <= seg_next;
    for (int i = 0; i <= NUM_NOTES; i++) begin
      bound[i] <= bound_next[i];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_NOTES; i++) begin
      hit[i] = ({1'b0, value} >= bound[i]) && ({1'b0, value} < bound[i+1]);
    end
  end

  // first matching segment wins; segments past the note registers use the last one
  always_comb begin
    hit_note = cfg.notes[LAST];
    for (int i = NUM_NOTES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_note = cfg.notes[(i > dmanq_pkg::NOTE_REGS - 1) ? dmanq_pkg::NOTE_REGS - 1 : i];
      end
    end
  end

  assign d_lo = $signed({2'b00, value}) - $signed({2'b00, cfg.range_start});
  assign d_hi = $signed({2'b00, value}) - $signed({2'b00, cfg.range_end});
  assign a_lo = d_lo[SW+1] ? (SW+1)'(-d_lo) : d_lo[SW:0];
  assign a_hi = d_hi[SW+1] ? (SW+1)'(-d_hi) : d_hi[SW:0];
  assign near_lo = a_lo < a_hi;

  assign base = (|hit) ? hit_note : (near_lo ? cfg.notes[0] : cfg.notes[LAST]);

  assign sum9 = $signed({2'b00, base}) +
                $signed({{2{cfg.transpose[NW-1]}}, cfg.transpose});

  // saturate to the note range
  always_comb begin
    priority if (sum9[NW+1]) begin
      note_next = '0;
    end else if (sum9[NW]) begin
      note_next = '1;
    end else begin
      note_next = sum9[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      note <= note_next;
    end
  end

endmodule
